FILE: rtl/windowed_frame_rate_meter_macros.svh
// Assertion helpers for the frame-rate meter.
`ifndef WINDOWED_FRAME_RATE_METER_MACROS_SVH
`define WINDOWED_FRAME_RATE_METER_MACROS_SVH

// Check that a condition holds at every clock edge outside reset
`define WFRM_ASSERT_HOLDS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequence holds in the same cycle as its cause
`define WFRM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a consequence holds in the cycle after its cause
`define WFRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/wfrm_pkg.sv
`timescale 1ns / 1ps
package wfrm_pkg;

    // Ring geometry
    localparam int DEFAULT_HISTORY_DEPTH = 10;

    // Nanoseconds per second; the Q24.8 scaling is a shift of eight
    localparam logic [29:0] NS_PER_S = 30'd1000000000;

    // Dividend width: 64-bit frames times 30-bit constant, shifted by eight
    localparam int PROD_W = 94;
    localparam int DVD_W  = PROD_W + 8;
    localparam int DIV_STEPS = DVD_W;

    // Reset values
    localparam logic [23:0] RESET_SAMPLE_INTERVAL = 24'd15;
    localparam logic [7:0]  RESET_NORMAL_INTERVAL = 8'd10;

    // Configuration register indexes
    localparam logic [0:0] CFG_FAST_FORWARD    = 1'd0;
    localparam logic [0:0] CFG_NORMAL_INTERVAL = 1'd1;

    // One ring entry
    typedef struct packed {
        logic [63:0] frame_count;
        logic [63:0] real_time_ns;
        logic [63:0] logical_time_ns;
    } t_entry;

endpackage

FILE: rtl/windowed_frame_rate_meter.sv
`timescale 1ns / 1ps
// Windowed frame-rate meter.
// Input channel (i_valid / o_ready): one transaction per frame tick, carrying
// the running frame number and real and logical time stamps in ns.
// Output channel (o_valid / i_ready): frames per real and logical second in
// unsigned Q24.8, saturated, with a flag for each zero elapsed time.
// Configuration: i_cfg_we writes register i_cfg_idx (0 fast_forward,
// 1 normal_interval) from i_cfg_data with no wait.
// A tick that takes no sample leaves the block idle. A sampling tick reads and
// rewrites one history entry and, once the ring is full, forms the differences,
// both multiplier halves and their sum, then runs two restoring dividers in
// parallel over a 102-bit dividend, one quotient bit per cycle.
// A result is produced only on a sampling tick after the ring has wrapped.
// Reset clears the ring pointer, fill flag, tick counter and control registers; the
// history memory needs no clearing since unfilled entries are never reported.
// If the receiver stalls, the finished result waits in the output register and
// the next tick is still taken; a further result holds the block until the
// output register frees up.
`include "windowed_frame_rate_meter_macros.svh"
module windowed_frame_rate_meter #(
    parameter int HISTORY_DEPTH = wfrm_pkg::DEFAULT_HISTORY_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_frame_count,
    input  logic [63:0] i_real_time_ns,
    input  logic [63:0] i_logical_time_ns,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_real_rate,
    output logic [31:0] o_logical_rate,
    output logic        o_real_time_stalled,
    output logic        o_logical_time_stalled
);
    import wfrm_pkg::*;

    localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);
    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIFF   = 3'd1;
    localparam logic [2:0] S_MUL_LO = 3'd2;
    localparam logic [2:0] S_MUL_HI = 3'd3;
    localparam logic [2:0] S_SUM    = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0]        r_state;
    logic              r_ff;
    logic [7:0]        r_normal;
    logic [23:0]       r_tick;
    logic [23:0]       r_interval;
    logic [SLOT_W-1:0] r_slot;
    logic              r_full;
    t_entry            r_in;
    t_entry            r_rd;
    t_entry            mem [HISTORY_DEPTH];
    logic [63:0]       r_dfr, r_drt, r_dlt;
    logic [61:0]       r_prod_lo, r_prod_hi;
    logic [DVD_W-1:0]  r_dvd;
    logic [CNT_W-1:0]  r_cnt;
    logic [63:0]       r_rem_r, r_rem_l;
    logic [31:0]       r_q_r, r_q_l;
    logic              r_sat_r, r_sat_l;
    logic              r_out_valid;
    logic [31:0]       r_out_rr, r_out_lr;
    logic              r_out_rs, r_out_ls;

    logic              w_accept;
    logic [23:0]       n_tick;
    logic [23:0]       n_interval;
    logic              w_sample;
    logic              w_mem_we;
    logic [31:0]       w_mul_a;
    logic [61:0]       w_mul_p;
    logic [PROD_W-1:0] w_prod;
    logic [64:0]       n_trial_r, n_trial_l;
    logic              n_qbit_r, n_qbit_l;
    logic [63:0]       n_rem_r, n_rem_l;
    logic [31:0]       n_rr, n_lr;
    logic              w_out_load;

    // Input handshake and tick decimation
    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign n_interval = r_ff ? r_interval : {16'd0, r_normal};
    assign n_tick     = r_tick + 24'd1;
    assign w_sample   = !(n_tick < n_interval);
    assign w_mem_we   = (r_state == S_DIFF);

    // Share one 32 x 30 multiplier between the two halves of the frame count
    assign w_mul_a = (r_state == S_MUL_LO) ? r_dfr[31:0] : r_dfr[63:32];
    assign w_mul_p = {30'd0, w_mul_a} * {32'd0, NS_PER_S};
    assign w_prod  = {32'd0, r_prod_lo} + {r_prod_hi, 32'd0};

    // One restoring step for each divisor
    always_comb begin
        n_trial_r = {r_rem_r, r_dvd[DVD_W-1]};
        n_trial_l = {r_rem_l, r_dvd[DVD_W-1]};
        n_qbit_r  = (n_trial_r >= {1'b0, r_drt});
        n_qbit_l  = (n_trial_l >= {1'b0, r_dlt});
        n_rem_r   = n_qbit_r ? 64'(n_trial_r - {1'b0, r_drt}) : n_trial_r[63:0];
        n_rem_l   = n_qbit_l ? 64'(n_trial_l - {1'b0, r_dlt}) : n_trial_l[63:0];
    end

    // Saturate, and force zero where the elapsed time was zero
    always_comb begin
        n_rr = (r_drt == 64'd0) ? 32'd0 : (r_sat_r ? 32'hFFFF_FFFF : r_q_r);
        n_lr = (r_dlt == 64'd0) ? 32'd0 : (r_sat_l ? 32'hFFFF_FFFF : r_q_l);
    end

    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || i_ready);

    // History memory: registered read on a sampling tick, write-back in the next cycle.
    // The sequencer does not return to idle before the write, so a read never
    // meets an entry still in flight.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[r_slot] <= r_in;
        end
        if (w_accept && w_sample) begin
            r_rd <= mem[r_slot];
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ff     <= 1'b0;
            r_normal <= RESET_NORMAL_INTERVAL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FAST_FORWARD:    r_ff     <= i_cfg_data[0];
                CFG_NORMAL_INTERVAL: r_normal <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_tick     <= 24'd0;
            r_interval <= RESET_SAMPLE_INTERVAL;
            r_slot     <= '0;
            r_full     <= 1'b0;
            r_cnt      <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_interval <= n_interval;
                        if (w_sample) begin
                            r_tick  <= 24'd0;
                            r_state <= S_DIFF;
                        end else begin
                            r_tick <= n_tick;
                        end
                    end
                end
                S_DIFF: begin
                    // Advance the ring; report only once it has wrapped before
                    if (r_slot == LAST_SLOT) begin
                        r_slot <= '0;
                        r_full <= 1'b1;
                    end else begin
                        r_slot <= r_slot + SLOT_W'(1);
                    end
                    r_state <= r_full ? S_MUL_LO : S_IDLE;
                end
                S_MUL_LO: r_state <= S_MUL_HI;
                S_MUL_HI: r_state <= S_SUM;
                S_SUM: begin
                    r_cnt   <= CNT_LAST;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        if (r_ff) begin
                            r_interval <= {2'd0, n_rr[31:10]};
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.frame_count     <= i_frame_count;
            r_in.real_time_ns    <= i_real_time_ns;
            r_in.logical_time_ns <= i_logical_time_ns;
        end
        if (r_state == S_DIFF) begin
            r_dfr <= r_in.frame_count - r_rd.frame_count;
            r_drt <= r_in.real_time_ns - r_rd.real_time_ns;
            r_dlt <= r_in.logical_time_ns - r_rd.logical_time_ns;
        end
        if (r_state == S_MUL_LO) begin
            r_prod_lo <= w_mul_p;
        end
        if (r_state == S_MUL_HI) begin
            r_prod_hi <= w_mul_p;
        end
        if (r_state == S_SUM) begin
            r_dvd   <= {w_prod, 8'd0};
            r_rem_r <= 64'd0;
            r_rem_l <= 64'd0;
            r_q_r   <= 32'd0;
            r_q_l   <= 32'd0;
            r_sat_r <= 1'b0;
            r_sat_l <= 1'b0;
        end
        if (r_state == S_DIV) begin
            // Shift one dividend bit into both remainders; a quotient bit
            // leaving the 32-bit window marks saturation
            r_dvd   <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem_r <= n_rem_r;
            r_rem_l <= n_rem_l;
            r_q_r   <= {r_q_r[30:0], n_qbit_r};
            r_q_l   <= {r_q_l[30:0], n_qbit_l};
            r_sat_r <= r_sat_r | r_q_r[31];
            r_sat_l <= r_sat_l | r_q_l[31];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_rr <= n_rr;
            r_out_lr <= n_lr;
            r_out_rs <= (r_drt == 64'd0);
            r_out_ls <= (r_dlt == 64'd0);
        end
    end

    assign o_valid                = r_out_valid;
    assign o_real_rate            = r_out_rr;
    assign o_logical_rate         = r_out_lr;
    assign o_real_time_stalled    = r_out_rs;
    assign o_logical_time_stalled = r_out_ls;

    // Checks
    `WFRM_ASSERT_HOLDS(a_slot_range, i_clk, i_rst_n, r_slot <= LAST_SLOT, "ring slot out of range")
    `WFRM_ASSERT_IMPLIES(a_div_full, i_clk, i_rst_n, r_state == S_DIV, r_full, "division before ring full")
    `WFRM_ASSERT_IMPLIES(a_stall_zero, i_clk, i_rst_n, o_valid && o_real_time_stalled, o_real_rate == 32'd0, "stalled real time with nonzero rate")
    `WFRM_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, w_out_load, o_valid && r_state == S_IDLE, "loaded result not presented")

endmodule

FILE: verif/tb_windowed_frame_rate_meter.sv
`timescale 1ns / 1ps

// One rate reading as the output channel presents it
typedef struct packed {
    logic [31:0] real_rate;
    logic [31:0] logical_rate;
    logic        real_stalled;
    logic        logical_stalled;
} t_rate_reading;

// Tracks the meter's ring and sampling state and checks each rate reading
class rate_scoreboard;
    t_rate_reading readings_due[$];
    logic [63:0]   frame_hist[wfrm_pkg::DEFAULT_HISTORY_DEPTH];
    logic [63:0]   real_hist[wfrm_pkg::DEFAULT_HISTORY_DEPTH];
    logic [63:0]   logical_hist[wfrm_pkg::DEFAULT_HISTORY_DEPTH];
    int unsigned   ring_pos;
    bit            ring_wrapped;
    logic [23:0]   tick_cnt;
    logic [23:0]   sample_every;
    bit            fast_fwd;
    logic [7:0]    normal_every;
    int            errors;
    int            checked;
    int            stalled_seen;

    function new();
        ring_pos     = 0;
        ring_wrapped = 1'b0;
        tick_cnt     = '0;
        sample_every = wfrm_pkg::RESET_SAMPLE_INTERVAL;
        fast_fwd     = 1'b0;
        normal_every = wfrm_pkg::RESET_NORMAL_INTERVAL;
        errors       = 0;
        checked      = 0;
        stalled_seen = 0;
    endfunction

    function void set_reg(logic [0:0] idx, logic [7:0] data);
        if (idx == wfrm_pkg::CFG_FAST_FORWARD) begin
            fast_fwd = data[0];
        end else begin
            normal_every = data;
        end
    endfunction

    // Frames per second over a span of ns, Q24.8, truncated and saturated
    function logic [31:0] q8_rate(logic [63:0] frames, logic [63:0] span);
        logic [127:0] num;
        logic [127:0] quo;
        num = {64'd0, frames} * 128'd256000000000;
        quo = num / {64'd0, span};
        return (quo > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
    endfunction

    // Note an accepted frame tick and queue the reading it produces, if any
    function void note_tick(logic [63:0] fc, logic [63:0] rt, logic [63:0] lt);
        logic [63:0]   dfr;
        logic [63:0]   drt;
        logic [63:0]   dlt;
        bit            was_wrapped;
        t_rate_reading r;
        if (!fast_fwd) sample_every = {16'd0, normal_every};
        tick_cnt = tick_cnt + 24'd1;
        if (tick_cnt < sample_every) return;
        tick_cnt = '0;
        was_wrapped = ring_wrapped;
        dfr = fc - frame_hist[ring_pos];
        drt = rt - real_hist[ring_pos];
        dlt = lt - logical_hist[ring_pos];
        frame_hist[ring_pos]   = fc;
        real_hist[ring_pos]    = rt;
        logical_hist[ring_pos] = lt;
        ring_pos++;
        if (ring_pos >= wfrm_pkg::DEFAULT_HISTORY_DEPTH) begin
            ring_pos     = 0;
            ring_wrapped = 1'b1;
        end
        if (!was_wrapped) return;
        r.real_stalled    = (drt == 64'd0);
        r.logical_stalled = (dlt == 64'd0);
        r.real_rate       = r.real_stalled ? 32'd0 : q8_rate(dfr, drt);
        r.logical_rate    = r.logical_stalled ? 32'd0 : q8_rate(dfr, dlt);
        if (fast_fwd) sample_every = {8'd0, r.real_rate[31:8]} / 24'd4;
        readings_due.push_back(r);
    endfunction

    task report(string msg);
        errors++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Compare one accepted reading with the oldest one due
    task check_reading(logic [31:0] rr, logic [31:0] lr, logic rs, logic ls);
        t_rate_reading want;
        checked++;
        if (rs || ls) stalled_seen++;
        if (readings_due.size() == 0) begin
            report($sformatf("reading with none due: real %h logical %h", rr, lr));
            return;
        end
        want = readings_due.pop_front();
        if (rr !== want.real_rate)
            report($sformatf("real_rate %h, want %h", rr, want.real_rate));
        if (lr !== want.logical_rate)
            report($sformatf("logical_rate %h, want %h", lr, want.logical_rate));
        if (rs !== want.real_stalled)
            report($sformatf("real_time_stalled %b, want %b", rs, want.real_stalled));
        if (ls !== want.logical_stalled)
            report($sformatf("logical_time_stalled %b, want %b", ls, want.logical_stalled));
    endtask
endclass

module tb_windowed_frame_rate_meter;
    import wfrm_pkg::*;

    localparam int SETTLE_CYCLES = 200;
    localparam logic [63:0] NS_60HZ = 64'd16_666_667;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_idx;
    logic [7:0]  i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [63:0] i_frame_count;
    logic [63:0] i_real_time_ns;
    logic [63:0] i_logical_time_ns;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_real_rate;
    logic [31:0] o_logical_rate;
    logic        o_real_time_stalled;
    logic        o_logical_time_stalled;

    rate_scoreboard sb = new();
    bit          quiet = 1'b0;
    int          rx_hold = 0;
    int          tx_calm = 0;
    int          ticks_sent = 0;
    logic [63:0] frame_pos;
    logic [63:0] real_pos;
    logic [63:0] logical_pos;

    windowed_frame_rate_meter i_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_idx              (i_cfg_idx),
        .i_cfg_data             (i_cfg_data),
        .i_valid                (i_valid),
        .o_ready                (o_ready),
        .i_frame_count          (i_frame_count),
        .i_real_time_ns         (i_real_time_ns),
        .i_logical_time_ns      (i_logical_time_ns),
        .o_valid                (o_valid),
        .i_ready                (i_ready),
        .o_real_rate            (o_real_rate),
        .o_logical_rate         (o_logical_rate),
        .o_real_time_stalled    (o_real_time_stalled),
        .o_logical_time_stalled (o_logical_time_stalled)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Write one register; the block takes it at the next edge
    task automatic write_reg(input logic [0:0] idx, input logic [7:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.set_reg(idx, data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Offer one frame tick and hold it until the transaction completes
    task automatic send_tick(input logic [63:0] fc, input logic [63:0] rt,
                             input logic [63:0] lt);
        i_valid           <= 1'b1;
        i_frame_count     <= fc;
        i_real_time_ns    <= rt;
        i_logical_time_ns <= lt;
        @(negedge i_clk);
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);
        sb.note_tick(fc, rt, lt);
        ticks_sent++;
    endtask

    // Drop valid for a random burst now and then, with calm stretches between
    task automatic sender_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet) return;
        if (tx_calm > 0) begin
            tx_calm--;
            return;
        end
        if (roll < 25) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end else if (roll < 35) begin
            tx_calm = $urandom_range(20, 60);
        end
    endtask

    // Advance the running stream by one tick, mostly well formed
    task automatic send_stream_tick(input bit slow_clock);
        logic [63:0] fc;
        logic [63:0] rt;
        logic [63:0] lt;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 90) frame_pos += 64'd1;
        else if (!slow_clock) frame_pos += 64'($urandom_range(0, 3));
        if (slow_clock) begin
            if (pick % 10 != 0) real_pos += 64'($urandom_range(20_000_000, 400_000_000));
        end else begin
            real_pos += 64'($urandom_range(0, 50_000_000));
        end
        if (pick < 70) logical_pos += NS_60HZ;
        else logical_pos += 64'($urandom_range(0, 100_000_000));
        if (pick >= 95) real_pos = {$urandom, $urandom};
        fc = frame_pos;
        rt = real_pos;
        lt = logical_pos;
        // Throw in unrelated values now and then, frames only off slow clocks
        if (pick >= 88 && pick < 95) begin
            rt = {$urandom, $urandom};
            lt = {$urandom, $urandom};
            if (!slow_clock) fc = {$urandom, $urandom};
        end
        send_tick(fc, rt, lt);
    endtask

    // Wait until every reading has arrived and the block has gone quiet
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.readings_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_stream(input int count, input bit slow_clock);
        int n;
        for (n = 0; n < count; n++) begin
            send_stream_tick(slow_clock);
            sender_gap();
        end
    endtask

    // Check each output transaction as it completes
    initial begin
        forever begin
            @(negedge i_clk);
            if (i_rst_n && o_valid && i_ready)
                sb.check_reading(o_real_rate, o_logical_rate, o_real_time_stalled,
                                 o_logical_time_stalled);
        end
    end

    // Receiver pacing: long hold when asked, random bursts otherwise
    initial begin : rx_pacing
        int burst;
        int calm;
        int roll;
        burst   = 0;
        calm    = 0;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            roll = $urandom_range(0, 99);
            if (quiet) begin
                i_ready <= 1'b1;
            end else if (rx_hold > 0) begin
                i_ready <= 1'b0;
                rx_hold--;
            end else if (burst > 0) begin
                i_ready <= 1'b0;
                burst--;
            end else if (calm > 0) begin
                i_ready <= 1'b1;
                calm--;
            end else if (roll < 15) begin
                i_ready <= 1'b0;
                burst = $urandom_range(0, 9);
            end else if (roll < 20) begin
                i_ready <= 1'b1;
                calm = $urandom_range(20, 80);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("windowed_frame_rate_meter regression: fail");
        $finish;
    end

    initial begin : stimulus
        logic [63:0] d_fc[24];
        logic [63:0] d_rt[24];
        logic [63:0] d_lt[24];
        int          i;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_FAST_FORWARD;
        i_cfg_data        = 8'd0;
        i_valid           = 1'b0;
        i_frame_count     = '0;
        i_real_time_ns    = '0;
        i_logical_time_ns = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: sample every tick, fill the ring, then the corner cases
        write_reg(CFG_FAST_FORWARD, 8'd0);
        write_reg(CFG_NORMAL_INTERVAL, 8'd1);
        for (i = 0; i < 24; i++) begin
            d_fc[i] = 64'(i * 3);
            d_rt[i] = 64'(i) * NS_60HZ;
            d_lt[i] = d_rt[i];
            case (i)
                // all ones, later wrapping round to zero
                9: begin
                    d_fc[i] = '1;
                    d_rt[i] = '1;
                    d_lt[i] = '1;
                end
                // real clock frozen
                11: d_rt[i] = d_rt[1];
                // logical clock frozen
                12: d_lt[i] = d_lt[2];
                // nothing moves at all
                13: begin
                    d_fc[i] = d_fc[3];
                    d_rt[i] = d_rt[3];
                    d_lt[i] = d_lt[3];
                end
                // real time runs backwards by one ns
                14: d_rt[i] = d_rt[4] - 64'd1;
                // frame count runs backwards, one ns elapsed: saturate
                15: begin
                    d_fc[i] = d_fc[5] - 64'd1;
                    d_rt[i] = d_rt[5] + 64'd1;
                end
                // one frame in one ns real, one second logical
                16: begin
                    d_fc[i] = d_fc[6] + 64'd1;
                    d_rt[i] = d_rt[6] + 64'd1;
                    d_lt[i] = d_lt[6] + 64'd1_000_000_000;
                end
                17: begin
                    d_fc[i] = d_fc[7] + 64'h8000_0000_0000_0000;
                    d_rt[i] = '1;
                end
                18: begin
                    d_rt[i] = '0;
                    d_lt[i] = '1;
                end
                19: begin
                    d_fc[i] = '0;
                    d_rt[i] = '0;
                    d_lt[i] = '0;
                end
                // no new frames while time moves on
                20: d_fc[i] = d_fc[10];
                default: ;
            endcase
            send_tick(d_fc[i], d_rt[i], d_lt[i]);
            sender_gap();
        end
        settle();

        // Short interval under a long output hold-off so the block backs up
        frame_pos   = {$urandom, $urandom};
        real_pos    = {$urandom, $urandom};
        logical_pos = {$urandom, $urandom};
        write_reg(CFG_NORMAL_INTERVAL, 8'd3);
        rx_hold = 600;
        run_stream(100, 1'b0);
        settle();

        // Fast-forward on slow clocks keeps the derived interval small
        write_reg(CFG_FAST_FORWARD, 8'd1);
        run_stream(90, 1'b1);
        settle();

        // Longest normal interval
        write_reg(CFG_FAST_FORWARD, 8'd0);
        write_reg(CFG_NORMAL_INTERVAL, 8'd255);
        run_stream(260, 1'b0);
        settle();

        // Closing stretch at full rate on both sides
        write_reg(CFG_NORMAL_INTERVAL, 8'd2);
        quiet = 1'b1;
        run_stream(40, 1'b0);
        settle();

        $display("%0d frame ticks sent, %0d rate readings checked, %0d with a frozen clock",
                 ticks_sent, sb.checked, sb.stalled_seen);
        $display("intervals 1 to 255, fast-forward, wrapped and saturated rates, output hold-off");
        if (sb.errors == 0) begin
            $display("windowed_frame_rate_meter regression: pass");
        end else begin
            $display("windowed_frame_rate_meter regression: fail");
        end
        $finish;
    end

endmodule

FILE: windowed_frame_rate_meter.f
+incdir+rtl
rtl/wfrm_pkg.sv
rtl/windowed_frame_rate_meter.sv
verif/tb_windowed_frame_rate_meter.sv
